// File: rtl/tdfr_pkg.sv
package tdfr_pkg;

    // Frame geometry
    localparam int DISK_FRAME_WORDS    = 2500;
    localparam int HEADER_REGION_WORDS = 160;
    localparam int FRAME_OUT_WORDS     = 20000;
    localparam int HDR_WORDS           = 4;

    localparam int POS_W  = $clog2(FRAME_OUT_WORDS);
    localparam int WDF_W  = $clog2(DISK_FRAME_WORDS);
    localparam int HCNT_W = $clog2(HDR_WORDS);

    // Field widths
    localparam int WORD_W     = 32;
    localparam int FPS_W      = 14;
    localparam int DAY_W      = 10;
    localparam int SEC_W      = 17;
    localparam int FRAC_W     = 14;
    localparam int FRAC_NUM_W = 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int QUEUE_DEPTH = 2;

    // Marker words
    localparam logic [WORD_W-1:0] SYNC_MARK    = 32'habaddeed;
    localparam logic [WORD_W-1:0] INVALID_MARK = 32'h11223344;
    localparam logic [WORD_W-1:0] HDR1_BASE    = 32'hbead0000;
    localparam logic [WORD_W-1:0] HDR1_KEEP    = 32'hffff8000;

    localparam logic [FRAC_W-1:0] FRAC_SCALE = 14'd10000;
    localparam logic [FRAC_W-1:0] FRAC_MAX   = 14'd9999;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACK_MODE = 3'd0,
        REG_FPS        = 3'd1,
        REG_DAY        = 3'd2,
        REG_START_SEC  = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              track_mode;
        logic [FPS_W-1:0]  frames_per_second;
        logic [DAY_W-1:0]  day_code;
        logic [SEC_W-1:0]  start_second;
    } cfg_t;

    // One queued item: one data word, or two for a 64-track pair
    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic              pair;
    } queue_entry_t;

    typedef struct packed {
        logic                  start;
        logic [FRAC_NUM_W-1:0] frac_num;
        logic [FPS_W-1:0]      frac_den;
        logic [DAY_W-1:0]      day_code;
        logic [SEC_W-1:0]      seconds;
    } prep_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] time_word;
        logic [WORD_W-1:0] frac_word;
    } hdr_fields_t;

    typedef enum logic [1:0] {
        BK_CHECK,
        BK_PREP,
        BK_HDR,
        BK_DATA
    } back_state_t;

    typedef enum logic [2:0] {
        PR_IDLE,
        PR_DIV,
        PR_SAT,
        PR_BCD,
        PR_DONE
    } prep_state_t;

    // Track-to-sample bit maps
    typedef logic [4:0] track_index_t;
    typedef track_index_t track_map_t [16];

    localparam track_map_t SRC32_LO = '{5'd0, 5'd8, 5'd4, 5'd12, 5'd16, 5'd24, 5'd20, 5'd28,
                                        5'd1, 5'd9, 5'd5, 5'd13, 5'd17, 5'd25, 5'd21, 5'd29};
    localparam track_map_t SRC32_HI = '{5'd2, 5'd10, 5'd6, 5'd14, 5'd18, 5'd26, 5'd22, 5'd30,
                                        5'd3, 5'd11, 5'd7, 5'd15, 5'd19, 5'd27, 5'd23, 5'd31};
    localparam track_map_t SRC64_S0 = '{5'd0, 5'd8, 5'd4, 5'd12, 5'd16, 5'd20, 5'd24, 5'd28,
                                        5'd1, 5'd5, 5'd9, 5'd13, 5'd17, 5'd21, 5'd25, 5'd29};
    localparam track_map_t SRC64_S1 = '{5'd2, 5'd10, 5'd6, 5'd14, 5'd18, 5'd22, 5'd26, 5'd30,
                                        5'd3, 5'd7, 5'd11, 5'd15, 5'd19, 5'd23, 5'd27, 5'd31};

endpackage

// File: rtl/tdfr_if.sv
interface tdfr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

interface tdfr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic        is_header;
    logic        last;

    modport source (output valid, output out_word, output is_header, output last, input ready);
    modport sink   (input valid, input out_word, input is_header, input last, output ready);
endinterface

// File: rtl/tdfr_front.sv
module tdfr_front (
    input  logic                   clk,
    input  logic                   rst_n,
    tdfr_in_if.sink                in_ch,
    input  logic                   track_mode,
    input  logic                   q_full,
    output logic                   q_push,
    output tdfr_pkg::queue_entry_t q_entry
);
    import tdfr_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next, pos_adv;
    logic [WORD_W-1:0] held_reg, held_next;
    logic              half_reg, half_next;
    logic              accept;
    logic              invalid;

    function automatic logic [15:0] gather16(input logic [WORD_W-1:0] w, input track_map_t src);
        logic [15:0] r;
        for (int i = 0; i < 16; i++)
            r[i] = w[src[i]];
        return r;
    endfunction

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign invalid     = pos_reg < POS_W'(HEADER_REGION_WORDS);
    assign pos_adv     = (pos_reg == POS_W'(FRAME_OUT_WORDS - 1)) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        q_push    = 1'b0;
        pos_next  = pos_reg;
        held_next = held_reg;
        half_next = half_reg;
        q_entry.pair  = track_mode;
        q_entry.word0 = {gather16(in_ch.data_word, SRC32_HI), gather16(in_ch.data_word, SRC32_LO)};
        q_entry.word1 = {gather16(in_ch.data_word, SRC64_S1), gather16(held_reg, SRC64_S1)};
        if (track_mode)
            q_entry.word0 = {gather16(in_ch.data_word, SRC64_S0), gather16(held_reg, SRC64_S0)};
        if (invalid)
        begin
            q_entry.word0 = INVALID_MARK;
            q_entry.word1 = INVALID_MARK;
        end
        if (accept)
        begin
            priority if (!track_mode)
            begin
                half_next = 1'b0;
                q_push    = 1'b1;
                pos_next  = pos_adv;
            end
            else if (!half_reg)
            begin
                // even word of a pair: hold it
                held_next = in_ch.data_word;
                half_next = 1'b1;
            end
            else
            begin
                half_next = 1'b0;
                q_push    = 1'b1;
                pos_next  = pos_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            half_reg <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// File: rtl/tdfr_fifo.sv
module tdfr_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tdfr_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   q_valid,
    output tdfr_pkg::queue_entry_t head
);
    import tdfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("queue pop while empty");

endmodule

// File: rtl/tdfr_hdr_calc.sv
module tdfr_hdr_calc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdfr_pkg::prep_req_t   req,
    output tdfr_pkg::hdr_fields_t fields
);
    import tdfr_pkg::*;

    localparam int DIV_STEPS = FRAC_NUM_W;
    localparam int BCD_STEPS = SEC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    prep_state_t state_reg, state_next;

    logic [CNT_W-1:0]      cnt_reg;
    logic [FRAC_NUM_W-1:0] num_reg;
    logic [FPS_W-1:0]      den_reg;
    logic [FPS_W-1:0]      rem_reg;
    logic [SEC_W-1:0]      sec_sh_reg, day_sh_reg, frac_sh_reg;
    logic [23:0]           bcd_sec_reg;
    logic [15:0]           bcd_day_reg, bcd_frac_reg;

    logic                  load, div_step, sat_step, bcd_step;
    logic [FPS_W:0]        rem_sh, rem_sub;
    logic                  ge;
    logic [FRAC_W-1:0]     frac_val;
    logic [23:0]           sec_adj, day_adj, frac_adj;

    function automatic logic [23:0] bcd_adjust(input logic [23:0] d);
        logic [23:0] r;
        for (int i = 0; i < 6; i++)
            r[i*4 +: 4] = (d[i*4 +: 4] >= 4'd5) ? d[i*4 +: 4] + 4'd3 : d[i*4 +: 4];
        return r;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PR_IDLE, PR_DONE:
                if (req.start)
                    state_next = PR_DIV;
            PR_DIV:
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = PR_SAT;
            PR_SAT:
                state_next = PR_BCD;
            PR_BCD:
                if (cnt_reg == CNT_W'(BCD_STEPS - 1))
                    state_next = PR_DONE;
            default:
                state_next = PR_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        load     = req.start && (state_reg == PR_IDLE || state_reg == PR_DONE);
        div_step = state_reg == PR_DIV;
        sat_step = state_reg == PR_SAT;
        bcd_step = state_reg == PR_BCD;
    end

    // restoring divide, one quotient bit per cycle
    assign rem_sh  = {rem_reg, num_reg[FRAC_NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        if (den_reg == '0)
            frac_val = '0;
        else if (num_reg > FRAC_NUM_W'(FRAC_MAX))
            frac_val = FRAC_MAX;
        else
            frac_val = num_reg[FRAC_W-1:0];
    end

    assign sec_adj  = bcd_adjust(bcd_sec_reg);
    assign day_adj  = bcd_adjust({8'b0, bcd_day_reg});
    assign frac_adj = bcd_adjust({8'b0, bcd_frac_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load || sat_step || (div_step && cnt_reg == CNT_W'(DIV_STEPS - 1)))
                cnt_reg <= '0;
            else if (div_step || bcd_step)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg    <= req.frac_num;
            den_reg    <= req.frac_den;
            rem_reg    <= '0;
            sec_sh_reg <= req.seconds;
            day_sh_reg <= {{(SEC_W - DAY_W){1'b0}}, req.day_code};
        end
        else if (div_step)
        begin
            num_reg <= {num_reg[FRAC_NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[FPS_W-1:0] : rem_sh[FPS_W-1:0];
        end
        else if (sat_step)
        begin
            frac_sh_reg  <= {{(SEC_W - FRAC_W){1'b0}}, frac_val};
            bcd_sec_reg  <= '0;
            bcd_day_reg  <= '0;
            bcd_frac_reg <= '0;
        end
        else if (bcd_step)
        begin
            // shift-add-3, MSB first; all three values padded to the same length
            bcd_sec_reg  <= {sec_adj[22:0], sec_sh_reg[SEC_W-1]};
            bcd_day_reg  <= {day_adj[14:0], day_sh_reg[SEC_W-1]};
            bcd_frac_reg <= {frac_adj[14:0], frac_sh_reg[SEC_W-1]};
            sec_sh_reg   <= {sec_sh_reg[SEC_W-2:0], 1'b0};
            day_sh_reg   <= {day_sh_reg[SEC_W-2:0], 1'b0};
            frac_sh_reg  <= {frac_sh_reg[SEC_W-2:0], 1'b0};
        end
    end

    assign fields.done      = state_reg == PR_DONE;
    assign fields.time_word = {bcd_day_reg[11:0], 20'b0} | {8'b0, bcd_sec_reg};
    assign fields.frac_word = {bcd_frac_reg, 16'b0};

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == PR_IDLE || state_reg == PR_DONE))
        else $error("header prep restarted while busy");

endmodule

// File: rtl/tdfr_back.sv
module tdfr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  tdfr_pkg::queue_entry_t        q_head,
    output logic                          q_pop,
    input  tdfr_pkg::cfg_t                cfg,
    input  logic                          sec_load,
    input  logic [tdfr_pkg::SEC_W-1:0]    sec_value,
    output tdfr_pkg::prep_req_t           prep,
    input  tdfr_pkg::hdr_fields_t         hdr,
    tdfr_out_if.source                    out_ch
);
    import tdfr_pkg::*;

    back_state_t state_reg, state_next;

    logic                  sel_reg;
    logic [HCNT_W-1:0]     hcnt_reg;
    logic [WDF_W-1:0]      wdf_reg;
    logic [FPS_W-1:0]      fis_reg;
    logic [SEC_W-1:0]      sec_reg;
    logic [FRAC_NUM_W-1:0] num_reg;
    logic [FPS_W-1:0]      den_reg;

    logic                  out_valid_reg;
    logic [WORD_W-1:0]     out_word_reg;
    logic                  out_hdr_reg;
    logic                  out_last_reg;

    logic                  out_free;
    logic                  load_hdr, load_data, word_last;
    logic [WDF_W:0]        wdf_inc;
    logic                  frame_end;
    logic [FPS_W-1:0]      fis_inc, fis_new;
    logic                  roll;
    logic [WORD_W-1:0]     hdr_word;

    assign out_free = !out_valid_reg || out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CHECK:
                if (q_valid)
                    state_next = (wdf_reg == '0) ? BK_PREP : BK_DATA;
            BK_PREP:
                if (hdr.done)
                    state_next = BK_HDR;
            BK_HDR:
                if (out_free && hcnt_reg == HCNT_W'(HDR_WORDS - 1))
                    state_next = BK_DATA;
            BK_DATA:
                if (out_free)
                    state_next = BK_CHECK;
            default:
                state_next = BK_CHECK;
        endcase
    end

    // control outputs
    always_comb
    begin
        load_hdr   = (state_reg == BK_HDR) && out_free;
        load_data  = (state_reg == BK_DATA) && out_free;
        word_last  = !q_head.pair || sel_reg;
        q_pop      = load_data && word_last;
    end

    assign prep.start    = (state_reg == BK_CHECK) && q_valid && (wdf_reg == '0);
    assign prep.frac_num = num_reg;
    assign prep.frac_den = den_reg;
    assign prep.day_code = cfg.day_code;
    assign prep.seconds  = sec_reg;

    // disk frame bookkeeping
    assign wdf_inc   = {1'b0, wdf_reg} + 1'b1;
    assign frame_end = wdf_inc >= (WDF_W + 1)'(DISK_FRAME_WORDS);
    assign fis_inc   = fis_reg + 1'b1;
    assign roll      = fis_inc == cfg.frames_per_second;
    assign fis_new   = roll ? '0 : fis_inc;

    always_comb
    begin
        unique case (hcnt_reg)
            2'd0:    hdr_word = SYNC_MARK;
            2'd1:    hdr_word = (HDR1_BASE & HDR1_KEEP) | {{(WORD_W - FPS_W){1'b0}}, fis_reg};
            2'd2:    hdr_word = hdr.time_word;
            default: hdr_word = hdr.frac_word;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CHECK;
            sel_reg       <= 1'b0;
            hcnt_reg      <= '0;
            wdf_reg       <= '0;
            fis_reg       <= '0;
            sec_reg       <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_hdr || load_data)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (load_hdr)
                hcnt_reg <= (hcnt_reg == HCNT_W'(HDR_WORDS - 1)) ? '0 : hcnt_reg + 1'b1;

            if (load_data)
            begin
                sel_reg <= !word_last;
                if (frame_end)
                begin
                    wdf_reg <= '0;
                    fis_reg <= fis_new;
                    num_reg <= {{(FRAC_NUM_W - FPS_W){1'b0}}, fis_new}
                             * {{(FRAC_NUM_W - FRAC_W){1'b0}}, FRAC_SCALE};
                    den_reg <= cfg.frames_per_second;
                    if (roll)
                        sec_reg <= sec_reg + 1'b1;
                end
                else
                    wdf_reg <= wdf_inc[WDF_W-1:0];
            end

            if (sec_load)
                sec_reg <= sec_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hdr)
        begin
            out_word_reg <= hdr_word;
            out_hdr_reg  <= 1'b1;
            out_last_reg <= 1'b0;
        end
        else if (load_data)
        begin
            out_word_reg <= sel_reg ? q_head.word1 : q_head.word0;
            out_hdr_reg  <= 1'b0;
            out_last_reg <= word_last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_word  = out_word_reg;
    assign out_ch.is_header = out_hdr_reg;
    assign out_ch.last      = out_last_reg;

    a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_hdr_reg |-> !out_last_reg)
        else $error("header word flagged as last");
    a_wdf_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wdf_reg} < (WDF_W + 1)'(DISK_FRAME_WORDS))
        else $error("disk frame word count out of range");
    a_hdr_ready: assert property (@(posedge clk) disable iff (!rst_n)
        load_hdr |-> hdr.done)
        else $error("header word sent before header fields were ready");

endmodule

// File: rtl/track_demux_frame_reformatter.sv
// Data path: a completed group is queued, then the back end moves each output word through its
//   check and data states into the output register; before each disk frame it first prepares
//   the header fields (28-step divide, saturate, 17-step BCD) and then sends 4 header words.
// The back-end fetch/emit sequencer handles one output data word at a time and stalls while
//   out_ch is not ready; in 64-track mode each word pair gives two output words, and a header
//   comes ahead of every 2500 data words.
// Reset: rst_n is asynchronous, active low; config registers return to their defaults
//   and all counters, the queue and the output stage clear. No clearing pass is needed.
module track_demux_frame_reformatter (
    input  logic                            clk,
    input  logic                            rst_n,
    tdfr_in_if.sink                         in_ch,
    tdfr_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [tdfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdfr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tdfr_pkg::*;

    // Configuration registers. A write to start_second also reloads the
    // running second count held in the back end.
    cfg_t         cfg_reg;
    logic         sec_load;

    // Front -> queue -> back
    logic         q_push, q_full, q_pop, q_valid;
    queue_entry_t q_in, q_head;

    // Back <-> header field unit
    prep_req_t    prep;
    hdr_fields_t  hdr;

    assign sec_load = cfg_we && (cfg_index == REG_START_SEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_mode        <= 1'b0;
            cfg_reg.frames_per_second <= 14'd6400;
            cfg_reg.day_code          <= '0;
            cfg_reg.start_second      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRACK_MODE: cfg_reg.track_mode        <= cfg_data[0];
                REG_FPS:        cfg_reg.frames_per_second <= cfg_data[FPS_W-1:0];
                REG_DAY:        cfg_reg.day_code          <= cfg_data[DAY_W-1:0];
                REG_START_SEC:  cfg_reg.start_second      <= cfg_data[SEC_W-1:0];
                default:        ;   // unknown index: ignored
            endcase
        end
    end

    // Front end: takes one recorder word per transfer, permutes tracks into
    // samples, swaps in the invalid marker inside the header region, and
    // queues one data word (32-track) or a word pair (64-track, on the odd word).
    tdfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .track_mode (cfg_reg.track_mode),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    // Short queue so the front keeps taking transfers, until the queue is full, while the back is busy
    // with a header or a stalled output.
    tdfr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .head       (q_head)
    );

    // Header fields: fraction of second by serial divide, then BCD of day,
    // second and fraction, computed just before each disk frame header.
    tdfr_hdr_calc u_hdr_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (prep),
        .fields (hdr)
    );

    // Back end: inserts the four-word header ahead of each disk frame, sends
    // data words through the output register and keeps the frame/second counts.
    tdfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .sec_load  (sec_load),
        .sec_value (cfg_data[SEC_W-1:0]),
        .prep      (prep),
        .hdr       (hdr),
        .out_ch    (out_ch)
    );

endmodule
